// ----- rtl/core/wide_integer_alu_top_macros.svh -----
// Assertion helpers for the top-level RTL file, which carries the checks.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef WIDE_INTEGER_ALU_TOP_MACROS_SVH
`define WIDE_INTEGER_ALU_TOP_MACROS_SVH

// Property that must hold in the same cycle.
`define WIA_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent in the next cycle.
`define WIA_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/wia_pkg.sv -----
`default_nettype none

package wia_pkg;

	// Port widths fixed by the interface
	localparam int DATA_W = 64;
	localparam int OP_W   = 3;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_QUO = 3'd3,
		OP_REM = 3'd4
	} op_t;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		DP_NOP    = 4'd0,
		DP_LOAD   = 4'd1,
		DP_ADD    = 4'd2,
		DP_SUB    = 4'd3,
		DP_MUL    = 4'd4,
		DP_DIV    = 4'd5,
		DP_DIVSEL = 4'd6,
		DP_DZ     = 4'd7
	} dp_op_t;

	// Sequencing modes of a microinstruction
	typedef enum logic [2:0] {
		SEQ_WAIT_IN  = 3'd0,
		SEQ_DISPATCH = 3'd1,
		SEQ_JUMP     = 3'd2,
		SEQ_LOOP     = 3'd3,
		SEQ_WAIT_OUT = 3'd4
	} seq_t;

	// Microprogram addresses
	typedef enum logic [3:0] {
		U_FETCH    = 4'd0,
		U_DISPATCH = 4'd1,
		U_ADD      = 4'd2,
		U_SUB      = 4'd3,
		U_MUL      = 4'd4,
		U_DIV      = 4'd5,
		U_DSEL     = 4'd6,
		U_DZ       = 4'd7,
		U_EMIT     = 4'd8
	} upc_t;

	typedef struct packed {
		dp_op_t dp_op;
		seq_t   seq;
		upc_t   target;
	} ucode_t;

	// Status fed back from the datapath to the sequencer
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            b_zero;
		logic            cnt_zero;
	} dp_stat_t;

	// Control store
	function automatic ucode_t ucode_rom(upc_t pc);
		ucode_t w;
		unique case (pc)
			U_FETCH:    w = '{DP_LOAD,   SEQ_WAIT_IN,  U_DISPATCH};
			U_DISPATCH: w = '{DP_NOP,    SEQ_DISPATCH, U_FETCH};
			U_ADD:      w = '{DP_ADD,    SEQ_JUMP,     U_EMIT};
			U_SUB:      w = '{DP_SUB,    SEQ_JUMP,     U_EMIT};
			U_MUL:      w = '{DP_MUL,    SEQ_LOOP,     U_EMIT};
			U_DIV:      w = '{DP_DIV,    SEQ_LOOP,     U_DSEL};
			U_DSEL:     w = '{DP_DIVSEL, SEQ_JUMP,     U_EMIT};
			U_DZ:       w = '{DP_DZ,     SEQ_JUMP,     U_EMIT};
			U_EMIT:     w = '{DP_NOP,    SEQ_WAIT_OUT, U_FETCH};
			default:    w = '{DP_NOP,    SEQ_JUMP,     U_FETCH};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/wide_integer_alu_top.sv -----
// Sequence: fetch, dispatch, then an add, subtract or zero-divisor step, a multiply loop,
// or a divide loop and select; unused codes go straight to emit.
// Throughput: one request at a time; multiply and divide retire one bit per cycle
// in the shared datapath, so a new request is taken once the result is registered.
// Reset: arst_n clears the microprogram counter and the output valid; no clearing pass.
`default_nettype none

`include "wide_integer_alu_top_macros.svh"

module wide_integer_alu_top #(
	parameter int WIDTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [wia_pkg::OP_W-1:0]         op,
	input  wire  [wia_pkg::DATA_W-1:0]       operand_a,
	input  wire  [wia_pkg::DATA_W-1:0]       operand_b,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [wia_pkg::DATA_W-1:0]       result_value,
	output logic                             divide_by_zero
);

	wia_pkg::upc_t     upc_q, upc_d, dispatch_pc;
	wia_pkg::ucode_t   uw;
	wia_pkg::dp_op_t   dp_cmd;
	wia_pkg::dp_stat_t stat;
	logic [WIDTH-1:0]  acc;
	logic              dz;
	logic              out_free, emit_fire;
	logic              out_valid_q;
	logic [wia_pkg::DATA_W-1:0] result_q;
	logic              dz_out_q;

	// Current microinstruction
	assign uw = wia_pkg::ucode_rom(upc_q);

	assign in_ready  = (uw.seq == wia_pkg::SEQ_WAIT_IN);
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (uw.seq == wia_pkg::SEQ_WAIT_OUT) && out_free;
	assign dp_cmd    = (uw.seq == wia_pkg::SEQ_WAIT_IN && !in_valid) ? wia_pkg::DP_NOP
	                                                                 : uw.dp_op;

	// Operation dispatch
	always_comb begin
		unique case (stat.op)
			wia_pkg::OP_ADD: dispatch_pc = wia_pkg::U_ADD;
			wia_pkg::OP_SUB: dispatch_pc = wia_pkg::U_SUB;
			wia_pkg::OP_MUL: dispatch_pc = wia_pkg::U_MUL;
			wia_pkg::OP_QUO, wia_pkg::OP_REM:
				dispatch_pc = stat.b_zero ? wia_pkg::U_DZ : wia_pkg::U_DIV;
			default:         dispatch_pc = wia_pkg::U_EMIT;
		endcase
	end

	// Next microprogram address
	always_comb begin
		upc_d = upc_q;
		unique case (uw.seq)
			wia_pkg::SEQ_WAIT_IN:  if (in_valid) upc_d = uw.target;
			wia_pkg::SEQ_DISPATCH: upc_d = dispatch_pc;
			wia_pkg::SEQ_JUMP:     upc_d = uw.target;
			wia_pkg::SEQ_LOOP:     if (stat.cnt_zero) upc_d = uw.target;
			wia_pkg::SEQ_WAIT_OUT: if (out_free) upc_d = uw.target;
			default:               upc_d = wia_pkg::U_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= wia_pkg::U_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

	wia_datapath #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.dp_op  (dp_cmd),
		.in_op  (op),
		.in_a   (operand_a[WIDTH-1:0]),
		.in_b   (operand_b[WIDTH-1:0]),
		.acc    (acc),
		.dz     (dz),
		.stat   (stat)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_q <= wia_pkg::DATA_W'(acc);
			dz_out_q <= dz;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_value   = result_q;
	assign divide_by_zero = dz_out_q;

	// Checks
	`WIA_CHECK_NEXT(a_fetch_dispatch, in_valid && in_ready, upc_q == wia_pkg::U_DISPATCH, "request not dispatched")
	`WIA_CHECK(a_dz_zero, !(out_valid && divide_by_zero) || result_value == '0, "divide by zero with nonzero result")
	`WIA_CHECK_NEXT(a_emit_valid, emit_fire, out_valid, "emitted result not valid")
	`WIA_CHECK(a_high_clear, !out_valid || (result_value >> WIDTH) == '0, "result bits above WIDTH set")

endmodule

`default_nettype wire

// ----- rtl/core/wia_datapath.sv -----
`default_nettype none

module wia_datapath #(
	parameter int WIDTH = 64
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire wia_pkg::dp_op_t     dp_op,
	input  wire [wia_pkg::OP_W-1:0]  in_op,
	input  wire [WIDTH-1:0]          in_a,
	input  wire [WIDTH-1:0]          in_b,
	output logic [WIDTH-1:0]         acc,
	output logic                     dz,
	output wia_pkg::dp_stat_t        stat
);

	localparam int CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0]         a_q, b_q, acc_q, rem_q;
	logic                     dz_q;
	logic [wia_pkg::OP_W-1:0] op_q;
	logic [CNT_W-1:0]         cnt_q;

	// One restoring division step: bring in the next dividend bit, try the subtract
	logic [WIDTH:0] trial;
	logic [WIDTH:0] diff;
	logic           qbit;

	assign trial = {rem_q, a_q[WIDTH-1]};
	assign diff  = trial - {1'b0, b_q};
	assign qbit  = ~diff[WIDTH];

	// Iteration count, operation code and divide-by-zero flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op_q  <= '0;
			dz_q  <= 1'b0;
		end else begin
			unique case (dp_op)
				wia_pkg::DP_LOAD: begin
					cnt_q <= CNT_W'(WIDTH - 1);
					op_q  <= in_op;
					dz_q  <= 1'b0;
				end
				wia_pkg::DP_MUL, wia_pkg::DP_DIV: cnt_q <= cnt_q - 1'b1;
				wia_pkg::DP_DZ: dz_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Operand, accumulator and partial remainder
	always_ff @(posedge clk) begin
		unique case (dp_op)
			wia_pkg::DP_LOAD: begin
				a_q   <= in_a;
				b_q   <= in_b;
				acc_q <= '0;
				rem_q <= '0;
			end
			wia_pkg::DP_ADD: acc_q <= a_q + b_q;
			wia_pkg::DP_SUB: acc_q <= a_q + ~b_q + 1'b1;
			wia_pkg::DP_MUL: begin
				if (b_q[0])
					acc_q <= acc_q + a_q;
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
			wia_pkg::DP_DIV: begin
				// a_q shifts the dividend out and the quotient in
				rem_q <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
				a_q   <= {a_q[WIDTH-2:0], qbit};
			end
			wia_pkg::DP_DIVSEL:
				acc_q <= (op_q == wia_pkg::OP_QUO) ? a_q : rem_q;
			wia_pkg::DP_DZ: acc_q <= '0;
			default: ;
		endcase
	end

	assign acc           = acc_q;
	assign dz            = dz_q;
	assign stat.op       = op_q;
	assign stat.b_zero   = (b_q == '0);
	assign stat.cnt_zero = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- tb/wide_integer_alu_top_test.sv -----
module wide_integer_alu_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = wia_pkg::DATA_W;
	localparam int OP_W   = wia_pkg::OP_W;

	localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] TOP_BIT  = {1'b1, {(DATA_W-1){1'b0}}};

	// Codes with no operation behind them
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	// Idle rates per phase, percent of cycles
	localparam int NUM_PHASES      = 4;
	localparam int SEND_IDLE[4]    = '{0, 60, 0, 12};
	localparam int RECV_STALL[4]   = '{0, 0, 60, 12};
	localparam int RANDOM_PER_PHASE = 460;
	localparam int SETTLE_CYCLES   = 80;

	typedef struct {
		logic [OP_W-1:0]   code;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		int                phase;
		bit                drain;
	} alu_request_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              dz;
	} alu_result_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     op = '0;
	logic [DATA_W-1:0]   operand_a = '0;
	logic [DATA_W-1:0]   operand_b = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [DATA_W-1:0]   result_value;
	logic                divide_by_zero;

	alu_request_t pending_requests[$];
	alu_result_t  expected_results[$];
	int           requests_sent   = 0;
	int           results_checked = 0;
	int           error_count     = 0;
	int           cur_phase       = 0;

	wide_integer_alu_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_value   (result_value),
		.divide_by_zero (divide_by_zero)
	);

	always #4 clk = ~clk;

	// Expected result of one request; division by zero flags and returns zero
	function automatic alu_result_t predict_result(logic [OP_W-1:0] code,
			logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		alu_result_t r;
		r.value = '0;
		r.dz    = 1'b0;
		case (code)
			wia_pkg::OP_ADD: r.value = a + b;
			wia_pkg::OP_SUB: r.value = a + ~b + 1'b1;
			wia_pkg::OP_MUL: r.value = a * b;
			wia_pkg::OP_QUO, wia_pkg::OP_REM: begin
				if (b == '0) begin
					r.dz = 1'b1;
				end else if (code == wia_pkg::OP_QUO) begin
					r.value = a / b;
				end else begin
					r.value = a % b;
				end
			end
			default: r.value = '0;
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			2: return TOP_BIT >> $urandom_range(DATA_W-1);
			3: return DATA_W'($urandom_range(255));
			default: return {$urandom, $urandom} >> $urandom_range(DATA_W-1);
		endcase
	endfunction

	task automatic queue_request(logic [OP_W-1:0] code, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, int phase, bit drain);
		alu_request_t req;
		req.code  = code;
		req.a     = a;
		req.b     = b;
		req.phase = phase;
		req.drain = drain;
		pending_requests.push_back(req);
	endtask

	task automatic flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	// Driver: records each accepted request, then presents the next one
	always @(posedge clk) begin : driver
		alu_request_t nxt;
		bit           taken;
		int           in_flight;
		if (arst_n) begin
			taken = in_valid && in_ready;
			if (taken) begin
				expected_results.push_back(predict_result(op, operand_a, operand_b));
				requests_sent <= requests_sent + 1;
			end
			if (!in_valid || taken) begin
				in_flight = requests_sent + int'(taken) - results_checked;
				if (pending_requests.size() > 0
						&& !(pending_requests[0].drain && in_flight != 0)
						&& $urandom_range(99) >= SEND_IDLE[pending_requests[0].phase]) begin
					nxt = pending_requests.pop_front();
					in_valid  <= 1'b1;
					op        <= nxt.code;
					operand_a <= nxt.a;
					operand_b <= nxt.b;
					cur_phase <= nxt.phase;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares each result with the oldest expectation
	always @(posedge clk) begin : monitor
		alu_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result value=%h dz=%b",
						result_value, divide_by_zero));
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want.value)
						flag_error($sformatf("result %0d: value expected %h got %h",
							results_checked, want.value, result_value));
					if (divide_by_zero !== want.dz)
						flag_error($sformatf("result %0d: divide_by_zero expected %b got %b",
							results_checked, want.dz, divide_by_zero));
					results_checked <= results_checked + 1;
				end
			end
			out_ready <= ($urandom_range(99) >= RECV_STALL[cur_phase]);
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		logic [OP_W-1:0]   code;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;

		// directed: field extremes and division corner cases
		queue_request(wia_pkg::OP_ADD, '0, '0, 0, 1'b0);
		queue_request(wia_pkg::OP_ADD, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_ADD, ALL_ONES, 64'd1, 0, 1'b0);
		queue_request(wia_pkg::OP_SUB, '0, 64'd1, 0, 1'b0);
		queue_request(wia_pkg::OP_SUB, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_SUB, 64'h0123_4567_89ab_cdef, '0, 0, 1'b0);
		queue_request(wia_pkg::OP_MUL, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_MUL, TOP_BIT, 64'd2, 0, 1'b0);
		queue_request(wia_pkg::OP_MUL, '0, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_MUL, 64'hdead_beef_cafe_f00d,
			64'h1234_5678_9abc_def1, 0, 1'b0);
		// zero divisor
		queue_request(wia_pkg::OP_QUO, ALL_ONES, '0, 0, 1'b0);
		queue_request(wia_pkg::OP_REM, 64'd5, '0, 0, 1'b0);
		queue_request(wia_pkg::OP_QUO, '0, '0, 0, 1'b0);
		// zero dividend
		queue_request(wia_pkg::OP_QUO, '0, 64'd7, 0, 1'b0);
		queue_request(wia_pkg::OP_REM, '0, ALL_ONES, 0, 1'b0);
		// divisor larger than dividend, then divisors of one and three and equal or near-equal operands
		queue_request(wia_pkg::OP_QUO, 64'd10, 64'd11, 0, 1'b0);
		queue_request(wia_pkg::OP_REM, 64'd10, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_QUO, ALL_ONES, 64'd1, 0, 1'b0);
		queue_request(wia_pkg::OP_REM, ALL_ONES, 64'd3, 0, 1'b0);
		queue_request(wia_pkg::OP_QUO, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_request(wia_pkg::OP_REM, TOP_BIT, TOP_BIT - 1'b1, 0, 1'b0);
		queue_request(wia_pkg::OP_QUO, TOP_BIT, 64'd1, 0, 1'b0);
		// unused codes
		queue_request(OP_SPARE_FIRST, ALL_ONES, ALL_ONES, 0, 1'b0);
		queue_request(OP_SPARE_MID, ALL_ONES, '0, 0, 1'b0);
		queue_request(OP_SPARE_LAST, 64'd9, 64'd3, 0, 1'b0);

		// random: one block per idle phase, each opened after a full drain
		for (int p = 0; p < NUM_PHASES; p++) begin
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				if ($urandom_range(99) < 6)
					code = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
				else
					code = OP_W'($urandom_range(wia_pkg::OP_REM, wia_pkg::OP_ADD));
				a = pick_operand();
				b = pick_operand();
				if ((code == wia_pkg::OP_QUO || code == wia_pkg::OP_REM)
						&& $urandom_range(3) == 0)
					b = a >> $urandom_range(8);
				queue_request(code, a, b, p, i == 0);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_requests.size() != 0 || in_valid)
			@(posedge clk);
		while (results_checked != requests_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_results.size() != 0)
			flag_error($sformatf("%0d expected results never arrived",
				expected_results.size()));

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/wia_pkg.sv
rtl/core/wia_datapath.sv
rtl/core/wide_integer_alu_top.sv
tb/wide_integer_alu_top_test.sv
